/* design/vlcp_pkg.sv */
// ----------------------------------------------------------------------------
// vlcp_pkg
// Shared types and constants of the variable-length code packer.
// ----------------------------------------------------------------------------
package vlcp_pkg;

    localparam int SYM_W   = 8;   // symbol field
    localparam int CODE_W  = 32;  // code word and code store entry
    localparam int LEN_W   = 6;   // code length field
    localparam int BYTE_W  = 8;   // packed output byte
    localparam int POS_W   = 3;   // bit position within a byte

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Command handed from the front end to the bit packer.
    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_cmd;

endpackage

/* design/vlcp_item_if.sv */
// ----------------------------------------------------------------------------
// vlcp_item_if
// Input action channel: valid/ready handshake with action payload.
// ----------------------------------------------------------------------------
interface vlcp_item_if;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [vlcp_pkg::SYM_W-1:0]  symbol;
    logic [vlcp_pkg::CODE_W-1:0] code_bits;
    logic [vlcp_pkg::LEN_W-1:0]  code_len;

    modport source (output valid, output action, output symbol, output code_bits,
                    output code_len, input ready);
    modport sink   (input valid, input action, input symbol, input code_bits,
                    input code_len, output ready);

endinterface

/* design/vlcp_byte_if.sv */
// ----------------------------------------------------------------------------
// vlcp_byte_if
// Output byte channel: valid/ready handshake with packed byte payload.
// ----------------------------------------------------------------------------
interface vlcp_byte_if;

    logic                       valid;
    logic                       ready;
    logic [vlcp_pkg::BYTE_W-1:0] out_byte;
    logic                       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);

endinterface

/* design/vlcp_front.sv */
// ----------------------------------------------------------------------------
// vlcp_front
// Accepts actions, keeps the code table, looks up codes and issues
// encode and flush commands to the command queue.
// ----------------------------------------------------------------------------
module vlcp_front #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 127
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    vlcp_item_if.sink          i_item,
    output logic               o_push,
    output vlcp_pkg::t_cmd     o_cmd,
    input  logic               i_full
);

    localparam int LenCap = (MAX_CODE_LEN < vlcp_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : vlcp_pkg::CODE_W;
    localparam int LW     = $clog2(LenCap + 1);
    localparam int AW     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    logic [vlcp_pkg::CODE_W-1:0] r_code_mem [SYMBOL_COUNT];
    logic [LW-1:0]               r_len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]     r_len_vld;

    logic                        r_s1_vld;
    logic                        r_s1_flush;
    logic [vlcp_pkg::CODE_W-1:0] r_s1_code;
    logic [LW-1:0]               r_s1_len;
    logic                        r_s1_lvld;

    logic                        acc;
    logic                        in_range;
    logic [AW-1:0]               addr;
    logic [vlcp_pkg::LEN_W-1:0]  len_clamp;
    logic [vlcp_pkg::CODE_W-1:0] code_mask;
    logic                        is_load;
    logic                        is_enc;
    logic                        is_flush;
    logic [vlcp_pkg::LEN_W-1:0]  s1_len;
    logic                        s1_drop;
    logic                        s1_done;

    assign in_range  = {1'b0, i_item.symbol} < (vlcp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
    assign addr      = i_item.symbol[AW-1:0];
    assign is_load   = (vlcp_pkg::t_action'(i_item.action) == vlcp_pkg::ACT_LOAD);
    assign is_enc    = (vlcp_pkg::t_action'(i_item.action) == vlcp_pkg::ACT_ENCODE);
    assign is_flush  = (vlcp_pkg::t_action'(i_item.action) == vlcp_pkg::ACT_FLUSH);
    assign len_clamp = (i_item.code_len > vlcp_pkg::LEN_W'(LenCap))
                     ? vlcp_pkg::LEN_W'(LenCap) : i_item.code_len;
    // clear code bits above the stored length
    assign code_mask = ~({vlcp_pkg::CODE_W{1'b1}} << len_clamp);

    assign s1_len  = r_s1_lvld ? vlcp_pkg::LEN_W'(r_s1_len) : '0;
    // drop encodes of empty codes here
    assign s1_drop = !r_s1_flush && (s1_len == '0);
    assign s1_done = r_s1_vld && (s1_drop || !i_full);

    assign i_item.ready = !r_s1_vld || s1_done;
    assign acc          = i_item.valid && i_item.ready;

    assign o_push      = r_s1_vld && !s1_drop && !i_full;
    assign o_cmd.flush = r_s1_flush;
    assign o_cmd.code  = r_s1_code;
    assign o_cmd.len   = s1_len;

    // code table, read data registered at the transfer
    always_ff @(posedge i_clk) begin
        if (acc && is_load && in_range) begin
            r_code_mem[addr] <= i_item.code_bits & code_mask;
            r_len_mem[addr]  <= LW'(len_clamp);
        end
        if (acc) begin
            r_s1_code  <= r_code_mem[addr];
            r_s1_len   <= r_len_mem[addr];
            r_s1_flush <= is_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
            r_s1_vld  <= 1'b0;
            r_s1_lvld <= 1'b0;
        end else begin
            if (acc && is_load && in_range) begin
                r_len_vld[addr] <= 1'b1;
            end
            if (acc) begin
                r_s1_vld  <= (is_enc && in_range) || is_flush;
                r_s1_lvld <= r_len_vld[addr];
            end else if (s1_done) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

endmodule

/* design/vlcp_queue.sv */
// ----------------------------------------------------------------------------
// vlcp_queue
// Short command queue between the front end and the bit packer.
// ----------------------------------------------------------------------------
module vlcp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vlcp_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output vlcp_pkg::t_cmd o_cmd
);

    vlcp_pkg::t_cmd                r_mem [vlcp_pkg::QUEUE_DEPTH];
    logic [vlcp_pkg::QPTR_W-1:0]   r_wptr;
    logic [vlcp_pkg::QPTR_W-1:0]   r_rptr;
    logic [vlcp_pkg::QCNT_W-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == vlcp_pkg::QCNT_W'(vlcp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/vlcp_back.sv */
// ----------------------------------------------------------------------------
// vlcp_back
// Bit packer: adds up to a byte of code bits per cycle to the pending byte,
// held on output stall; full or flushed bytes leave through an output register.
// ----------------------------------------------------------------------------
module vlcp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  vlcp_pkg::t_cmd i_cmd,
    output logic           o_pop,
    vlcp_byte_if.source    o_byte
);

    logic                        r_busy;
    logic                        r_flush;
    logic [vlcp_pkg::CODE_W-1:0] r_code;
    logic [vlcp_pkg::LEN_W-1:0]  r_len;
    logic [vlcp_pkg::BYTE_W-1:0] r_pend;
    logic [vlcp_pkg::POS_W-1:0]  r_pos;
    logic                        r_out_vld;
    logic [vlcp_pkg::BYTE_W-1:0] r_out_byte;
    logic                        r_out_last;

    logic [3:0]                  room;
    logic [3:0]                  take;
    logic [3:0]                  fill;
    logic                        full;
    logic [vlcp_pkg::BYTE_W-1:0] merged;
    logic [vlcp_pkg::LEN_W-1:0]  rem;
    logic                        emit;
    logic                        out_free;
    logic                        step;
    logic                        last_step;

    assign room   = 4'd8 - {1'b0, r_pos};
    assign take   = (r_len < vlcp_pkg::LEN_W'(room)) ? r_len[3:0] : room;
    assign fill   = {1'b0, r_pos} + take;
    assign full   = fill[3];
    // bits above the code length are zero, so no mask is needed
    assign merged = r_pend | (r_code[vlcp_pkg::BYTE_W-1:0] << r_pos);
    assign rem    = r_len - vlcp_pkg::LEN_W'(take);

    assign emit      = r_flush ? (r_pos != '0) : full;
    assign out_free  = !r_out_vld || o_byte.ready;
    assign step      = r_busy && (!emit || out_free);
    assign last_step = r_flush || (rem == '0);
    // take the next command in the cycle the current one finishes
    assign o_pop     = !i_empty && (!r_busy || (step && last_step));

    assign o_byte.valid       = r_out_vld;
    assign o_byte.out_byte    = r_out_byte;
    assign o_byte.last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code <= i_cmd.code;
            r_len  <= i_cmd.len;
        end else if (step && !r_flush) begin
            r_code <= r_code >> take;
            r_len  <= rem;
        end
        if (step && emit) begin
            r_out_byte <= r_flush ? r_pend : merged;
            r_out_last <= r_flush || (rem < vlcp_pkg::LEN_W'(vlcp_pkg::BYTE_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_flush   <= 1'b0;
            r_pend    <= '0;
            r_pos     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_flush <= i_cmd.flush;
            end else if (step && last_step) begin
                r_busy <= 1'b0;
            end

            if (step) begin
                if (r_flush || full) begin
                    r_pend <= '0;
                    r_pos  <= '0;
                end else begin
                    r_pend <= merged;
                    r_pos  <= fill[vlcp_pkg::POS_W-1:0];
                end
            end

            if (step && emit) begin
                r_out_vld <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

/* design/variable_length_code_packer.sv */
// ----------------------------------------------------------------------------
// variable_length_code_packer
// LSB-first packer of variable-length codes into bytes, with a loadable
// code table, a front end, a command queue and a bit packer.
// ----------------------------------------------------------------------------
// channel   direction  handshake      payload
// i_item    in         valid/ready    action, symbol, code_bits, code_len
// o_byte    out        valid/ready    out_byte, last_of_run
//
// An encode or flush passes through the table lookup stage and the queue, then the
// packer takes ceil((pending + code_len) / 8) steps for an encode (five at most
// for a 32-bit code) and one for a flush. The packer's one-step-per-cycle pace,
// held while the output stalls, sets the rate; a two-entry queue lets the front
// keep taking items until it fills while the packer works or the output stalls.
// Reset clears the length valid bits, the pending byte, queue and valid/busy flags.
// ----------------------------------------------------------------------------
module variable_length_code_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 127
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vlcp_item_if.sink   i_item,
    vlcp_byte_if.source o_byte
);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    vlcp_pkg::t_cmd push_cmd;
    vlcp_pkg::t_cmd head_cmd;

    vlcp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full)
    );

    vlcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    vlcp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule

/* tb/tb_variable_length_code_packer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_variable_length_code_packer
// Drives load, encode and flush actions into the code packer and predicts
// every packed byte from a local copy of the code table and pending byte.
// Covers directed corner cases, random symbol streams under input and output
// idling, and a long output stall that backs up the input channel.
// ----------------------------------------------------------------------------
module tb_variable_length_code_packer;

    localparam int SYMBOL_COUNT = 127;
    localparam int MAX_CODE_LEN = 32;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < vlcp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                     : vlcp_pkg::CODE_W;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [vlcp_pkg::BYTE_W-1:0] value;
        logic                        last;
    } t_packed_byte;

    logic i_clk;
    logic i_rst_n;

    vlcp_item_if item_if ();
    vlcp_byte_if byte_if ();

    variable_length_code_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_byte  (byte_if)
    );

    // Local copy of the packer state
    logic [vlcp_pkg::CODE_W-1:0] code_table [SYMBOL_COUNT];
    int                          len_table  [SYMBOL_COUNT];
    logic [vlcp_pkg::BYTE_W-1:0] pend_byte;
    int                          pend_bits;
    bit                          sym_written [SYMBOL_COUNT];
    int                          loaded_syms [$];

    t_packed_byte expected_bytes [$];
    t_packed_byte next_byte;

    int mismatches;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;
    logic hold_off;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes outstanding", $time, expected_bytes.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        byte_if.ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected byte: expected none, got %02h last %0b",
                         $time, byte_if.out_byte, byte_if.last_of_run);
            end else begin
                next_byte = expected_bytes.pop_front();
                if (byte_if.out_byte !== next_byte.value) begin
                    mismatches++;
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, next_byte.value, byte_if.out_byte);
                end
                if (byte_if.last_of_run !== next_byte.last) begin
                    mismatches++;
                    $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                             $time, next_byte.last, byte_if.last_of_run);
                end
            end
        end
    end

    // Work out the bytes one accepted action produces and queue them
    task automatic predict_packed_bytes(input vlcp_pkg::t_action act, input int sym,
                                        input logic [vlcp_pkg::CODE_W-1:0] bits,
                                        input int len);
        logic [vlcp_pkg::CODE_W-1:0] code;
        logic [vlcp_pkg::CODE_W-1:0] mask;
        int                          clen;
        t_packed_byte                outs [$];
        case (act)
            vlcp_pkg::ACT_LOAD: begin
                if (sym < SYMBOL_COUNT) begin
                    clen = (len > LEN_LIMIT) ? LEN_LIMIT : len;
                    mask = (clen >= vlcp_pkg::CODE_W) ? '1
                         : ((vlcp_pkg::CODE_W'(1) << clen) - vlcp_pkg::CODE_W'(1));
                    code_table[sym] = bits & mask;
                    len_table[sym]  = clen;
                    if (!sym_written[sym]) begin
                        sym_written[sym] = 1'b1;
                        loaded_syms.push_back(sym);
                    end
                end
            end
            vlcp_pkg::ACT_ENCODE: begin
                if (sym < SYMBOL_COUNT) begin
                    code = code_table[sym];
                    clen = len_table[sym];
                    for (int i = 0; i < clen; i++) begin
                        pend_byte[pend_bits] = code[i];
                        pend_bits++;
                        if (pend_bits == vlcp_pkg::BYTE_W) begin
                            outs.push_back('{value: pend_byte, last: 1'b0});
                            pend_byte = '0;
                            pend_bits = 0;
                        end
                    end
                end
            end
            vlcp_pkg::ACT_FLUSH: begin
                if (pend_bits > 0) begin
                    outs.push_back('{value: pend_byte, last: 1'b0});
                    pend_byte = '0;
                    pend_bits = 0;
                end
            end
            default: ;
        endcase
        if (outs.size() > 0)
            outs[outs.size()-1].last = 1'b1;
        foreach (outs[k])
            expected_bytes.push_back(outs[k]);
    endtask

    // Offer one action, idling first at random; valid stays high for a following item
    task automatic send_item(input vlcp_pkg::t_action act, input int sym,
                             input logic [vlcp_pkg::CODE_W-1:0] bits, input int len);
        while ($urandom_range(99) < tx_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.action    <= act;
        item_if.symbol    <= sym[vlcp_pkg::SYM_W-1:0];
        item_if.code_bits <= bits;
        item_if.code_len  <= len[vlcp_pkg::LEN_W-1:0];
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        predict_packed_bytes(act, sym, bits, len);
    endtask

    task automatic wait_for_drain();
        item_if.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int random_code_len();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 0;
        if (r < 60)
            return $urandom_range(1, 8);
        if (r < 88)
            return $urandom_range(9, 20);
        if (r < 97)
            return $urandom_range(21, 32);
        return $urandom_range(33, 63);
    endfunction

    task automatic test_directed_cases();
        tx_idle_pct = 12;
        rx_idle_pct = 65;
        send_item(vlcp_pkg::ACT_LOAD, 0, 32'h0000_0001, 1);
        send_item(vlcp_pkg::ACT_LOAD, SYMBOL_COUNT - 1, 32'hA5C3_0F96, 32);
        // empty code: stored bits must be cleared
        send_item(vlcp_pkg::ACT_LOAD, 5, 32'hFFFF_FFFF, 0);
        // over-long load clamps to the store width
        send_item(vlcp_pkg::ACT_LOAD, 7, 32'h8000_0001, 63);
        send_item(vlcp_pkg::ACT_LOAD, SYMBOL_COUNT, 32'h0000_00FF, 8);
        send_item(vlcp_pkg::ACT_LOAD, 255, 32'h0000_0007, 3);
        send_item(vlcp_pkg::ACT_LOAD, 9, 32'h0000_FFFF, 7);
        send_item(vlcp_pkg::ACT_FLUSH, 0, 32'h0, 0);
        send_item(vlcp_pkg::ACT_ENCODE, 0, 32'h0, 0);
        send_item(vlcp_pkg::ACT_ENCODE, SYMBOL_COUNT - 1, 32'h0, 0);
        send_item(vlcp_pkg::ACT_ENCODE, 5, 32'h0, 0);
        send_item(vlcp_pkg::ACT_ENCODE, SYMBOL_COUNT, 32'h0, 0);
        send_item(vlcp_pkg::ACT_ENCODE, 200, 32'hFFFF_FFFF, 63);
        send_item(vlcp_pkg::ACT_NONE, 255, 32'hFFFF_FFFF, 63);
        send_item(vlcp_pkg::ACT_FLUSH, 255, 32'hFFFF_FFFF, 63);
        // seven pending bits plus a full-length code give four bytes
        send_item(vlcp_pkg::ACT_ENCODE, 9, 32'h0, 0);
        send_item(vlcp_pkg::ACT_ENCODE, SYMBOL_COUNT - 1, 32'h0, 0);
        send_item(vlcp_pkg::ACT_ENCODE, 7, 32'h0, 0);
        send_item(vlcp_pkg::ACT_FLUSH, 0, 32'h0, 0);
        send_item(vlcp_pkg::ACT_LOAD, 0, 32'hFFFF_FF00, 8);
        send_item(vlcp_pkg::ACT_ENCODE, 0, 32'h0, 0);
        send_item(vlcp_pkg::ACT_ENCODE, 9, 32'h0, 0);
        send_item(vlcp_pkg::ACT_FLUSH, 0, 32'h0, 0);
        wait_for_drain();
    endtask

    task automatic test_random_stream(input int tx_pct, input int rx_pct, input int n_items);
        int done;
        int r;
        done = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (done < n_items) begin
            r = $urandom_range(99);
            if (r < 14) begin
                send_item(vlcp_pkg::ACT_LOAD, $urandom_range(SYMBOL_COUNT - 1), $urandom,
                          random_code_len());
                done++;
            end else if (r < 80) begin
                send_item(vlcp_pkg::ACT_ENCODE,
                          loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                          $urandom, $urandom_range(63));
                done++;
            end else if (r < 90) begin
                send_item(vlcp_pkg::ACT_FLUSH, $urandom_range(255), $urandom,
                          $urandom_range(63));
                done++;
            end else begin
                // ignored actions: out-of-range symbols and the unused code
                case ($urandom_range(2))
                    0: send_item(vlcp_pkg::ACT_LOAD, $urandom_range(SYMBOL_COUNT, 255),
                                 $urandom, $urandom_range(63));
                    1: send_item(vlcp_pkg::ACT_ENCODE, $urandom_range(SYMBOL_COUNT, 255),
                                 $urandom, $urandom_range(63));
                    default: send_item(vlcp_pkg::ACT_NONE, $urandom_range(255), $urandom,
                                       $urandom_range(63));
                endcase
                done++;
            end
        end
        wait_for_drain();
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int s = 0; s < 4; s++)
            send_item(vlcp_pkg::ACT_LOAD, 100 + s, $urandom, 29 + s);
        // hold the output off while long codes keep arriving
        fork
            begin
                hold_off <= 1'b1;
                repeat (STALL_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            for (int k = 0; k < 24; k++)
                send_item(vlcp_pkg::ACT_ENCODE, 100 + $urandom_range(3), $urandom, 0);
        join
        send_item(vlcp_pkg::ACT_FLUSH, 0, 32'h0, 0);
        wait_for_drain();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        item_if.valid     <= 1'b0;
        item_if.action    <= vlcp_pkg::ACT_NONE;
        item_if.symbol    <= '0;
        item_if.code_bits <= '0;
        item_if.code_len  <= '0;
        hold_off          <= 1'b0;
        mismatches  = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pend_byte   = '0;
        pend_bits   = 0;
        for (int k = 0; k < SYMBOL_COUNT; k++) begin
            code_table[k]  = '0;
            len_table[k]   = 0;
            sym_written[k] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_stream(12, 65, 85);
        test_random_stream(65, 12, 85);
        test_random_stream(0, 0, 85);
        test_output_stall();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
